// File: sv/csr_pkg.sv
`timescale 1ns / 1ps

package csr_pkg;

    // fixed field widths
    localparam int CX_W       = 14;
    localparam int FY_W       = CX_W + 1;
    localparam int RADIUS_W   = 5;
    localparam int SQ_W       = 2 * RADIUS_W;
    localparam int ROW_W      = 12;
    localparam int DIM_W      = 13;
    localparam int DIM_CAP    = 4096;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // reset values of the dimension registers
    localparam int DIM_RESET = 256;

    // parameter defaults
    localparam int MAX_RADIUS_DEF = 31;
    localparam int COORD_BITS_DEF = 12;

    // one row issued by the sequencer
    typedef struct packed {
        logic signed [RADIUS_W:0] y;
        logic [CX_W-1:0]          cx;
        logic [CX_W-1:0]          cy;
        logic [SQ_W-1:0]          r_sq;
        logic                     first;
        logic                     final_row;
    } row_cmd_t;

endpackage

// File: sv/csr_circle_if.sv
`timescale 1ns / 1ps

interface csr_circle_if;
    import csr_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [CX_W-1:0] center_x;
    logic signed [CX_W-1:0] center_y;
    logic [RADIUS_W-1:0]    radius;

    modport source (output valid, output center_x, output center_y, output radius,
                    input ready);
    modport sink   (input valid, input center_x, input center_y, input radius,
                    output ready);
endinterface

// File: sv/csr_span_if.sv
`timescale 1ns / 1ps

interface csr_span_if;
    import csr_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_y;
    logic [ROW_W-1:0] span_start;
    logic [ROW_W-1:0] span_end;
    logic             empty_res;
    logic             last;

    modport source (output valid, output row_y, output span_start, output span_end,
                    output empty_res, output last, input ready);
    modport sink   (input valid, input row_y, input span_start, input span_end,
                    input empty_res, input last, output ready);
endinterface

// File: sv/csr_row_seq.sv
`timescale 1ns / 1ps

module csr_row_seq #(
    parameter int MAX_RADIUS = csr_pkg::MAX_RADIUS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    csr_circle_if.sink        circle,
    input  logic              issue_en,
    output logic              cmd_valid,
    output csr_pkg::row_cmd_t cmd
);
    import csr_pkg::*;

    logic                     busy_reg;
    logic signed [RADIUS_W:0] y_reg;
    logic [RADIUS_W-1:0]      r_reg;
    logic [CX_W-1:0]          cx_reg;
    logic [CX_W-1:0]          cy_reg;
    logic [SQ_W-1:0]          r_sq_reg;
    logic                     first_reg;

    logic                     at_end;
    logic                     issue;
    logic                     accept;
    logic [RADIUS_W-1:0]      r_sat;
    logic [RADIUS_W:0]        y_start;

    assign at_end       = (y_reg == $signed({1'b0, r_reg}));
    assign issue        = busy_reg && issue_en;
    assign circle.ready = !busy_reg || (issue && at_end);
    assign accept       = circle.valid && circle.ready;

    assign r_sat   = (circle.radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS)
                                                            : circle.radius;
    assign y_start = ~{1'b0, r_sat} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (issue && at_end)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            y_reg     <= $signed(y_start);
            r_reg     <= r_sat;
            cx_reg    <= circle.center_x;
            cy_reg    <= circle.center_y;
            r_sq_reg  <= SQ_W'(r_sat) * SQ_W'(r_sat);
            first_reg <= 1'b1;
        end
        else if (issue)
        begin
            y_reg     <= y_reg + 1'b1;
            first_reg <= 1'b0;
        end
    end

    assign cmd_valid     = busy_reg;
    assign cmd.y         = y_reg;
    assign cmd.cx        = cx_reg;
    assign cmd.cy        = cy_reg;
    assign cmd.r_sq      = r_sq_reg;
    assign cmd.first     = first_reg;
    assign cmd.final_row = at_end;
endmodule

// File: sv/circle_scanline_rasterizer.sv
`timescale 1ns / 1ps

// circle to scanline spans. a circle is taken on the circle channel and the row
// sequencer walks its row offsets from -r to +r, one row a cycle while stage 1
// can take it, where r is the radius saturated to MAX_RADIUS; the next circle is
// taken in the cycle the last row of the current one leaves the sequencer. each
// row then passes three register stages: row square and image row, half-width
// search against a table of squares, column clamp into the output register.
// rows above or below the image make no span; a circle with no row inside the
// image gives one item with empty_res set. the final item of every circle
// carries last. the user must write image_width and image_height on the cfg
// port only while no circle is in flight; the block does not enforce this.
// zero reads as one and values beyond the coordinate range saturate.
module circle_scanline_rasterizer #(
    parameter int MAX_RADIUS = csr_pkg::MAX_RADIUS_DEF,
    parameter int COORD_BITS = csr_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    csr_circle_if.sink                       circle,
    csr_span_if.source                       span,
    input  logic                             cfg_we,
    input  logic [csr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import csr_pkg::*;

    // largest usable image dimension
    localparam int COORD_CAP = 1 << COORD_BITS;
    localparam int DIM_LIMIT = (COORD_CAP < DIM_CAP) ? COORD_CAP : DIM_CAP;

    // ---------------------------------------------------------------
    // configuration: held as the last column and the row count
    // ---------------------------------------------------------------
    logic [ROW_W-1:0] width_max_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] cfg_dim;

    always_comb
    begin
        cfg_dim = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_dim = DIM_W'(1);
        end
        else if (cfg_data > DIM_W'(DIM_LIMIT))
        begin
            cfg_dim = DIM_W'(DIM_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_max_reg <= ROW_W'(DIM_RESET - 1);
            height_reg    <= DIM_W'(DIM_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_max_reg <= ROW_W'(cfg_dim - 1'b1);
                CFG_IMAGE_HEIGHT: height_reg    <= cfg_dim;
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage enables: a stage loads when empty or when its item moves on
    // ---------------------------------------------------------------
    logic v1_reg;
    logic v2_reg;
    logic out_valid_reg;
    logic en1;
    logic en2;
    logic en3;

    assign en3 = !out_valid_reg || span.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    // ---------------------------------------------------------------
    // row sequencer
    // ---------------------------------------------------------------
    logic     cmd_valid;
    row_cmd_t cmd;

    csr_row_seq #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_row_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .circle    (circle),
        .issue_en  (en1),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // ---------------------------------------------------------------
    // stage 1: r*r - y*y and the image row
    // ---------------------------------------------------------------
    logic [SQ_W-1:0]     rem1_reg;
    logic [FY_W-1:0]     fy1_reg;
    logic [CX_W-1:0]     cx1_reg;
    logic                first1_reg;
    logic                final1_reg;

    logic [RADIUS_W:0]   y_neg;
    logic [RADIUS_W-1:0] y_mag;
    logic [SQ_W-1:0]     y_sq;
    logic [SQ_W-1:0]     rem1_next;
    logic [FY_W-1:0]     fy1_next;

    always_comb
    begin
        y_neg     = ~cmd.y + 1'b1;
        y_mag     = cmd.y[RADIUS_W] ? y_neg[RADIUS_W-1:0] : cmd.y[RADIUS_W-1:0];
        y_sq      = SQ_W'(y_mag) * SQ_W'(y_mag);
        // |y| <= r, so this never goes negative
        rem1_next = cmd.r_sq - y_sq;
        fy1_next  = {cmd.cy[CX_W-1], cmd.cy}
                  + {{(FY_W - RADIUS_W - 1){cmd.y[RADIUS_W]}}, cmd.y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en1)
        begin
            v1_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            rem1_reg   <= rem1_next;
            fy1_reg    <= fy1_next;
            cx1_reg    <= cmd.cx;
            first1_reg <= cmd.first;
            final1_reg <= cmd.final_row;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: half width and row keep / last decision
    // ---------------------------------------------------------------
    logic [RADIUS_W-1:0] hw2_reg;
    logic [ROW_W-1:0]    row2_reg;
    logic [CX_W-1:0]     cx2_reg;
    logic                keep2_reg;
    logic                empty2_reg;
    logic                last2_reg;
    logic                any_reg;

    logic [RADIUS_W-1:0] hw2_next;
    logic                in_img;
    logic                at_bottom;
    logic                seen;
    logic                keep2_next;
    logic                last2_next;
    logic [FY_W-1:0]     height_m1;

    // the fits form a thermometer, so the half width is the largest k that fits
    always_comb
    begin
        hw2_next = '0;
        for (int k = 1; k <= MAX_RADIUS; k++)
        begin
            if (SQ_W'(k * k) <= rem1_reg)
            begin
                hw2_next = RADIUS_W'(k);
            end
        end
    end

    always_comb
    begin
        height_m1  = FY_W'(height_reg) - 1'b1;
        in_img     = !fy1_reg[FY_W-1] && (fy1_reg[CX_W-1:0] < CX_W'(height_reg));
        at_bottom  = (fy1_reg == height_m1);
        seen       = first1_reg ? 1'b0 : any_reg;
        // surviving rows are contiguous, so the last one is either the bottom
        // image row or the final row of the circle
        keep2_next = in_img || (final1_reg && !seen);
        last2_next = in_img ? (final1_reg || at_bottom) : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg  <= 1'b0;
            any_reg <= 1'b0;
        end
        else if (en2)
        begin
            v2_reg <= v1_reg;
            if (v1_reg)
            begin
                any_reg <= seen || in_img;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            hw2_reg    <= hw2_next;
            row2_reg   <= fy1_reg[ROW_W-1:0];
            cx2_reg    <= cx1_reg;
            keep2_reg  <= keep2_next;
            empty2_reg <= !in_img;
            last2_reg  <= last2_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: clamp both ends into the output register
    // ---------------------------------------------------------------
    logic [ROW_W-1:0] row_y_reg;
    logic [ROW_W-1:0] span_start_reg;
    logic [ROW_W-1:0] span_end_reg;
    logic             empty_reg;
    logic             last_reg;

    logic [FY_W-1:0]  left_col;
    logic [FY_W-1:0]  right_col;
    logic [ROW_W-1:0] span_start_next;
    logic [ROW_W-1:0] span_end_next;
    logic [ROW_W-1:0] row_y_next;

    function automatic logic [ROW_W-1:0] clamp_col(input logic [FY_W-1:0] v,
                                                   input logic [ROW_W-1:0] wmax);
        logic [ROW_W-1:0] res;
        if (v[FY_W-1])
        begin
            res = '0;
        end
        else if (v[CX_W-1:0] > CX_W'(wmax))
        begin
            res = wmax;
        end
        else
        begin
            res = v[ROW_W-1:0];
        end
        return res;
    endfunction

    always_comb
    begin
        left_col  = {cx2_reg[CX_W-1], cx2_reg} - FY_W'(hw2_reg);
        right_col = {cx2_reg[CX_W-1], cx2_reg} + FY_W'(hw2_reg);
        if (empty2_reg)
        begin
            // empty circle: every span field reads zero
            span_start_next = '0;
            span_end_next   = '0;
            row_y_next      = '0;
        end
        else
        begin
            span_start_next = clamp_col(left_col, width_max_reg);
            span_end_next   = clamp_col(right_col, width_max_reg);
            row_y_next      = row2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en3)
        begin
            // dropped rows leave a bubble here
            out_valid_reg <= v2_reg && keep2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            row_y_reg      <= row_y_next;
            span_start_reg <= span_start_next;
            span_end_reg   <= span_end_next;
            empty_reg      <= empty2_reg;
            last_reg       <= last2_reg;
        end
    end

    assign span.valid      = out_valid_reg;
    assign span.row_y      = row_y_reg;
    assign span.span_start = span_start_reg;
    assign span.span_end   = span_end_reg;
    assign span.empty_res  = empty_reg;
    assign span.last       = last_reg;
endmodule
